[sv/occupancy_cell_probability_map_assert.svh]
// Assertion macros for the occupancy map checker.
`ifndef OCCUPANCY_CELL_PROBABILITY_MAP_ASSERT_SVH
`define OCCUPANCY_CELL_PROBABILITY_MAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCPM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("occupancy map check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCPM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("occupancy map check failed");

`endif

[sv/ocpm_pkg.sv]
package ocpm_pkg;

	// Map geometry and counter size.
	localparam int unsigned CELLS      = 4096;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned ADDR_W     = $clog2(CELLS);

	// Port field widths.
	localparam int unsigned TYPE_W  = 3;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned BYTE_W  = 8;

	// Divider widths: dividend is 255 * seen, divisor is seen + unseen.
	localparam int unsigned DIVD_W = COUNT_BITS + BYTE_W;
	localparam int unsigned SUM_W  = COUNT_BITS + 1;
	localparam int unsigned STEP_W = $clog2(BYTE_W);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam count_t CNT_MAX    = '1;
	localparam byte_t  EMPTY_BYTE = 8'd12;
	localparam byte_t  CAP_BYTE   = 8'd242;

	// Request codes; every other code behaves as a read.
	localparam logic [TYPE_W-1:0] REQ_INC_SEEN   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_SET_SEEN   = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_INC_UNSEEN = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_SET_UNSEEN = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_READ       = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// One memory word holds both counters of a cell.
	typedef struct packed {
		count_t seen;
		count_t unseen;
	} cell_t;

	// Increment that sticks at the counter maximum.
	function automatic count_t sat_inc(count_t v);
		return (v == CNT_MAX) ? CNT_MAX : v + count_t'(1);
	endfunction

	// Loads a request value, clamped to the counter range.
	function automatic count_t sat_set(logic [VALUE_W-1:0] v);
		return (32'(v) > 32'(CNT_MAX)) ? CNT_MAX : count_t'(v);
	endfunction

endpackage

[sv/occupancy_cell_probability_map.sv]
// Occupancy grid of 4096 cells, each with a 16-bit seen and unseen counter kept in one
// on-chip RAM word. A request increments or sets one counter of a cell, or only reads it,
// and always returns one word: the cell's occupancy byte after the update, which is
// floor(255 * seen / (seen + unseen)) capped at 242, or 12 for a cell with both counts zero.
// After reset the block runs a clearing pass over the RAM, one cell per cycle, and holds
// in_stall high until it is done. Requests are handled one at a time: a request passes
// through the RAM read, the write back and the 8-step restoring division that forms the
// byte (the division is skipped when both counts are zero) before its result is offered.
// The next request is accepted only once the result has moved to the output register and
// the block is back in idle. A finished word waits in the output register, so the next
// request can be taken while it is still stalled.
module occupancy_cell_probability_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ocpm_pkg::TYPE_W-1:0]  req_type,
	input  logic [ocpm_pkg::INDEX_W-1:0] cell_index,
	input  logic [ocpm_pkg::VALUE_W-1:0] new_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ocpm_pkg::BYTE_W-1:0]  prob_byte
);

	import ocpm_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [TYPE_W-1:0] type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [VALUE_W-1:0] value_q;
	logic oor_q;

	count_t seen_q, unseen_q;
	logic [SUM_W-1:0] sum;
	logic [DIVD_W-1:0] dividend;

	logic [SUM_W-1:0] div_d_q, rem_q;
	logic [BYTE_W-1:0] nlo_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W:0] trial;
	logic fits;
	byte_t quo_next;
	byte_t res_q;

	logic out_valid_q;
	byte_t prob_q;
	logic out_load;

	logic ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	cell_t ram_wdata, ram_rdata, cell_new;
	logic wr_op;

	ocpm_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(cell_index)),
		.rdata (ram_rdata)
	);

	// Apply the request to the counters read from memory.
	always_comb begin
		cell_new = ram_rdata;
		wr_op = 1'b1;
		case (type_q)
			REQ_INC_SEEN:   cell_new.seen = sat_inc(ram_rdata.seen);
			REQ_SET_SEEN:   cell_new.seen = sat_set(value_q);
			REQ_INC_UNSEEN: cell_new.unseen = sat_inc(ram_rdata.unseen);
			REQ_SET_UNSEEN: cell_new.unseen = sat_set(value_q);
			default:        wr_op = 1'b0;
		endcase
	end

	// Divider operands: 255 * seen as (seen << 8) - seen, and the total count.
	assign sum = SUM_W'(seen_q) + SUM_W'(unseen_q);
	assign dividend = DIVD_W'({seen_q, BYTE_W'(0)}) - DIVD_W'(seen_q);

	// One restoring division step.
	assign trial = {rem_q, nlo_q[BYTE_W-1]};
	assign fits = trial >= {1'b0, div_d_q};
	assign quo_next = {quo_q[BYTE_W-2:0], fits};

	// Sequencer: next state, memory port and handshake controls.
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = cell_new;
		ram_re = 1'b0;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				ram_re = in_valid;
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ram_we = wr_op && !oor_q;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = (sum == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_PREP) begin
				step_q <= STEP_W'(BYTE_W - 1);
			end else if (state_q == ST_DIV) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, counter update and division datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			type_q <= req_type;
			addr_q <= ADDR_W'(cell_index);
			value_q <= new_count;
			oor_q <= 32'(cell_index) >= 32'(CELLS);
		end
		if (state_q == ST_UPDATE) begin
			// A cell outside the map reads as empty.
			seen_q <= oor_q ? '0 : cell_new.seen;
			unseen_q <= oor_q ? '0 : cell_new.unseen;
		end
		if (state_q == ST_PREP) begin
			div_d_q <= sum;
			rem_q <= SUM_W'(dividend[DIVD_W-1:BYTE_W]);
			nlo_q <= dividend[BYTE_W-1:0];
			quo_q <= '0;
			res_q <= EMPTY_BYTE;
		end
		if (state_q == ST_DIV) begin
			rem_q <= fits ? SUM_W'(trial - {1'b0, div_d_q}) : SUM_W'(trial);
			nlo_q <= {nlo_q[BYTE_W-2:0], 1'b0};
			quo_q <= quo_next;
			if (step_q == '0) begin
				res_q <= (quo_next > CAP_BYTE) ? CAP_BYTE : quo_next;
			end
		end
		if (out_load) begin
			prob_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign prob_byte = prob_q;

endmodule

[sv/ocpm_ram.sv]
module ocpm_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/ocpm_checker.sv]
`include "occupancy_cell_probability_map_assert.svh"

module ocpm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ocpm_pkg::BYTE_W-1:0] prob_byte
);

	import ocpm_pkg::*;

	// A stalled result word stays offered and unchanged.
	`OCPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`OCPM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(prob_byte))

	// The occupancy byte never exceeds the ceiling.
	`OCPM_ASSERT_IMPL(a_cap, clk, arst_n, out_valid, prob_byte <= CAP_BYTE)

	// Requests are handled one at a time: the block is busy right after taking one.
	`OCPM_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

bind occupancy_cell_probability_map ocpm_checker u_ocpm_checker (.*);
